FILE: sv/rcmd_pkg.sv
// shared types and constants for the column-major run-length image decoder
// no dependencies; used by rcmd_seg_unit, rcmd_seq and the top level
`default_nettype none

package rcmd_pkg;

  localparam logic [7:0] ESCAPE_BYTE = 8'h7B;
  localparam int COUNT_W  = 9;
  localparam int MIN_ROWS = 8;
  localparam int TDATA_W  = 56;

  localparam logic [1:0] CFG_ROW_BYTES  = 2'd0;
  localparam logic [1:0] CFG_ROW_COUNT  = 2'd1;
  localparam logic [1:0] CFG_SKIP_BYTES = 2'd2;

  localparam logic [8:0]  ROW_BYTES_RST  = 9'd80;
  localparam logic [10:0] ROW_COUNT_RST  = 11'd200;
  localparam logic [15:0] SKIP_BYTES_RST = 16'd0;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_COUNT,
    PH_VALUE
  } phase_t;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_PREP,
    SEQ_SEG
  } seq_state_t;

  typedef struct packed {
    logic [7:0]         value;
    logic [COUNT_W-1:0] count;
  } run_req_t;

  typedef struct packed {
    logic [7:0]         column;
    logic [9:0]         start_row;
    logic [COUNT_W-1:0] length;
    logic [7:0]         value;
    logic               last_of_run;
    logic               image_done;
  } seg_t;

endpackage

`default_nettype wire

FILE: sv/rle_column_major_image_decoder.sv
// top level: escape-byte run-length decoder filling an image column by column
// depends on rcmd_pkg and rcmd_seq (which uses rcmd_seg_unit)
// flow: a byte that starts a run passes the column check state, then one column segment
//   per visit of the segment state moves into the output register; output stalls hold it
// input: bytes are refused while a run is split; escape and count bytes start no run
// reset: synchronous; parser, position, byte count and finish flags clear, registers 80/200/0
`default_nettype none

module rle_column_major_image_decoder #(
  parameter int MAX_COLUMNS = 256,
  parameter int MAX_ROWS    = 1024
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // input byte stream
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [7:0]                    s_axis_tdata,   // data_byte
  input  wire logic                          s_axis_tlast,   // end_of_stream
  // configuration writes
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [1:0]                    cfg_index,
  input  wire logic [15:0]                   cfg_data,
  // segment stream
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // column[7:0], start_row[17:8], length[26:18], value[34:27],
  // bytes_used[50:35], zero[55:51]
  output logic [rcmd_pkg::TDATA_W-1:0]       m_axis_tdata,
  output logic                               m_axis_tlast,   // last_of_run
  output logic                               m_axis_tuser    // image_done
);

  localparam int RNW = $clog2(MAX_ROWS+1);
  localparam int CW  = $clog2(MAX_COLUMNS+1);
  localparam int CBW = (CW > 9) ? CW : 9;
  localparam int RBW = (RNW > 11) ? RNW : 11;

  // configuration registers
  logic [8:0]  row_bytes;
  logic [10:0] row_count;
  logic [15:0] skip_bytes;

  // parser state
  rcmd_pkg::phase_t parse_phase;
  logic [7:0]       run_count_hold;
  logic [15:0]      byte_counter;
  logic             eos_seen;

  // effective image size after clamping
  logic [CW-1:0]  cols;
  logic [RNW-1:0] rows;

  logic               in_req;
  logic               finished;
  logic               skipping;
  logic               run_start;
  rcmd_pkg::run_req_t run_req;

  logic           seq_busy;
  logic           seg_valid;
  logic           seg_ready;
  rcmd_pkg::seg_t seg;
  logic           img_finished;

  // output register
  rcmd_pkg::seg_t out_seg;
  logic [15:0]    out_bytes;
  logic           out_valid;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_bytes  <= rcmd_pkg::ROW_BYTES_RST;
      row_count  <= rcmd_pkg::ROW_COUNT_RST;
      skip_bytes <= rcmd_pkg::SKIP_BYTES_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        rcmd_pkg::CFG_ROW_BYTES:  row_bytes  <= cfg_data[8:0];
        rcmd_pkg::CFG_ROW_COUNT:  row_count  <= cfg_data[10:0];
        rcmd_pkg::CFG_SKIP_BYTES: skip_bytes <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // width saturates to the column limit; height clamps into its legal range
  always_comb begin
    if (CBW'(row_bytes) > CBW'(MAX_COLUMNS)) begin
      cols = CW'(MAX_COLUMNS);
    end else begin
      cols = CW'(row_bytes);
    end
    if (row_count < 11'(rcmd_pkg::MIN_ROWS)) begin
      rows = RNW'(rcmd_pkg::MIN_ROWS);
    end else if (RBW'(row_count) > RBW'(MAX_ROWS)) begin
      rows = RNW'(MAX_ROWS);
    end else begin
      rows = RNW'(row_count);
    end
  end

  // bytes are taken whenever no run is in flight; once finished they are swallowed
  assign s_axis_tready = !seq_busy;
  assign in_req        = s_axis_tvalid && s_axis_tready;
  assign finished      = eos_seen || img_finished;
  assign skipping      = byte_counter < skip_bytes;

  always_comb begin
    run_start     = 1'b0;
    run_req.value = s_axis_tdata;
    run_req.count = rcmd_pkg::COUNT_W'(1);
    if (in_req && !finished && !skipping) begin
      case (parse_phase)
        rcmd_pkg::PH_VALUE: begin
          run_start     = 1'b1;
          run_req.count = rcmd_pkg::COUNT_W'(run_count_hold) + rcmd_pkg::COUNT_W'(1);
        end
        rcmd_pkg::PH_COUNT: begin
          run_start = 1'b0;
        end
        default: begin
          // plain literal unless it is the escape marker
          run_start = (s_axis_tdata != rcmd_pkg::ESCAPE_BYTE);
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase    <= rcmd_pkg::PH_IDLE;
      run_count_hold <= '0;
      byte_counter   <= '0;
      eos_seen       <= 1'b0;
    end else if (in_req && !finished) begin
      if (byte_counter != 16'hFFFF) begin
        byte_counter <= byte_counter + 16'd1;
      end
      if (!skipping) begin
        case (parse_phase)
          rcmd_pkg::PH_COUNT: begin
            run_count_hold <= s_axis_tdata;
            parse_phase    <= rcmd_pkg::PH_VALUE;
          end
          rcmd_pkg::PH_VALUE: begin
            parse_phase <= rcmd_pkg::PH_IDLE;
          end
          default: begin
            if (s_axis_tdata == rcmd_pkg::ESCAPE_BYTE) begin
              parse_phase <= rcmd_pkg::PH_COUNT;
            end else begin
              parse_phase <= rcmd_pkg::PH_IDLE;
            end
          end
        endcase
      end
      // end mark stops decoding once this byte's run is out; a pending escape is dropped
      if (s_axis_tlast) begin
        eos_seen <= 1'b1;
      end
    end
  end

  rcmd_seq #(
    .MAX_COLUMNS(MAX_COLUMNS),
    .MAX_ROWS   (MAX_ROWS)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .start        (run_start),
    .run_req      (run_req),
    .rows         (rows),
    .cols         (cols),
    .seg_ready    (seg_ready),
    .busy         (seq_busy),
    .seg_valid    (seg_valid),
    .seg          (seg),
    .img_finished (img_finished)
  );

  // single output register; a new segment loads when it is empty or draining
  assign seg_ready = !out_valid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (seg_ready) begin
      out_valid <= seg_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (seg_valid && seg_ready) begin
      out_seg   <= seg;
      out_bytes <= byte_counter;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {5'd0, out_bytes, out_seg.value, out_seg.length,
                          out_seg.start_row, out_seg.column};
  assign m_axis_tlast  = out_seg.last_of_run;
  assign m_axis_tuser  = out_seg.image_done;

`ifndef SYNTH
  // no byte request may be taken while a run is still being split
  a_no_accept_in_run: assert property (@(posedge clk) disable iff (rst)
    seg_valid |-> !s_axis_tready)
    else $error("byte accepted while a run is in flight");

  // decoding never resumes once finished
  a_finish_sticky: assert property (@(posedge clk) disable iff (rst)
    finished |=> finished)
    else $error("finish flag dropped");

  // the segment that fills the image always closes its run
  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast)
    else $error("image_done without last_of_run");
`endif

endmodule

`default_nettype wire

FILE: sv/rcmd_seg_unit.sv
// shared segment arithmetic: room subtract, length compare and next-row add per use
// depends on rcmd_pkg
`default_nettype none

module rcmd_seg_unit #(
  parameter int MAX_ROWS = 1024
) (
  input  wire logic [$clog2(MAX_ROWS+1)-1:0] rows,
  input  wire logic [$clog2(MAX_ROWS)-1:0]   row,
  input  wire logic [rcmd_pkg::COUNT_W-1:0]  count,
  output logic                               row_full,
  output logic [rcmd_pkg::COUNT_W-1:0]       seg_len,
  output logic                               wrap,
  output logic [$clog2(MAX_ROWS)-1:0]        row_next
);

  localparam int RNW = $clog2(MAX_ROWS+1);
  localparam int RW  = $clog2(MAX_ROWS);
  localparam int UW  = (RNW > rcmd_pkg::COUNT_W ? RNW : rcmd_pkg::COUNT_W) + 1;

  logic [UW-1:0] room;
  logic          take_all;

  always_comb begin
    // room left in the column; top bit is the borrow when row is past the height
    room     = UW'(rows) - UW'(row);
    row_full = room[UW-1] | (room == '0);
    take_all = UW'(count) < room;
    seg_len  = take_all ? count : rcmd_pkg::COUNT_W'(room);
    wrap     = !take_all;
    row_next = wrap ? '0 : RW'(UW'(row) + UW'(seg_len));
  end

endmodule

`default_nettype wire

FILE: sv/rcmd_seq.sv
// run sequencer: splits one run into column segments with the shared unit
// depends on rcmd_pkg and rcmd_seg_unit
`default_nettype none

module rcmd_seq #(
  parameter int MAX_COLUMNS = 256,
  parameter int MAX_ROWS    = 1024
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               start,
  input  wire rcmd_pkg::run_req_t                 run_req,
  input  wire logic [$clog2(MAX_ROWS+1)-1:0]      rows,
  input  wire logic [$clog2(MAX_COLUMNS+1)-1:0]   cols,
  input  wire logic                               seg_ready,
  output logic                                    busy,
  output logic                                    seg_valid,
  output rcmd_pkg::seg_t                          seg,
  output logic                                    img_finished
);

  localparam int RW = $clog2(MAX_ROWS);
  localparam int CW = $clog2(MAX_COLUMNS+1);

  rcmd_pkg::seq_state_t state, state_next;
  logic [RW-1:0]                 row, row_next;
  logic [CW-1:0]                 col, col_next;
  logic [rcmd_pkg::COUNT_W-1:0]  count, count_next;
  logic [7:0]                    value, value_next;
  logic                          img_finished_next;

  logic                          u_full;
  logic [rcmd_pkg::COUNT_W-1:0]  u_seg;
  logic                          u_wrap;
  logic [RW-1:0]                 u_row_next;
  logic [CW:0]                   col_inc;
  logic [CW:0]                   col_eff;
  logic [rcmd_pkg::COUNT_W-1:0]  count_left;
  logic                          done;

  rcmd_seg_unit #(
    .MAX_ROWS(MAX_ROWS)
  ) u_unit (
    .rows     (rows),
    .row      (row),
    .count    (count),
    .row_full (u_full),
    .seg_len  (u_seg),
    .wrap     (u_wrap),
    .row_next (u_row_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= rcmd_pkg::SEQ_IDLE;
      row          <= '0;
      col          <= '0;
      img_finished <= 1'b0;
    end else begin
      state        <= state_next;
      row          <= row_next;
      col          <= col_next;
      img_finished <= img_finished_next;
    end
  end

  always_ff @(posedge clk) begin
    count <= count_next;
    value <= value_next;
  end

  always_comb begin
    state_next        = state;
    row_next          = row;
    col_next          = col;
    count_next        = count;
    value_next        = value;
    img_finished_next = img_finished;
    busy              = (state != rcmd_pkg::SEQ_IDLE);
    seg_valid         = 1'b0;
    col_inc           = (CW+1)'(col) + (CW+1)'(1);
    col_eff           = (CW+1)'(col);
    count_left        = count - u_seg;
    done              = u_wrap && (col_inc >= (CW+1)'(cols));

    seg.column      = 8'(col);
    seg.start_row   = 10'(row);
    seg.length      = u_seg;
    seg.value       = value;
    seg.last_of_run = (count_left == '0) || done;
    seg.image_done  = done;

    case (state)
      rcmd_pkg::SEQ_IDLE: begin
        if (start) begin
          count_next = run_req.count;
          value_next = run_req.value;
          state_next = rcmd_pkg::SEQ_PREP;
        end
      end
      rcmd_pkg::SEQ_PREP: begin
        // a row past the height (after a height change) counts the column as full
        if (u_full) begin
          col_eff  = col_inc;
          row_next = '0;
        end
        col_next = CW'(col_eff);
        if (col_eff >= (CW+1)'(cols)) begin
          img_finished_next = 1'b1;
          state_next        = rcmd_pkg::SEQ_IDLE;
        end else begin
          state_next = rcmd_pkg::SEQ_SEG;
        end
      end
      rcmd_pkg::SEQ_SEG: begin
        seg_valid = 1'b1;
        if (seg_ready) begin
          count_next = count_left;
          row_next   = u_row_next;
          if (u_wrap) begin
            col_next = CW'(col_inc);
          end
          if (done) begin
            img_finished_next = 1'b1;
          end
          if (done || (count_left == '0)) begin
            state_next = rcmd_pkg::SEQ_IDLE;
          end
        end
      end
      default: begin
        state_next = rcmd_pkg::SEQ_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire
